FILE: hw/rtl/xid_pkg.sv
// package for the x86-64 subset decoder: phase codes, class codes, helpers
// no dependencies
`default_nettype none
package xid_pkg;
	typedef enum logic [2:0] {PH_PFX, PH_ESC, PH_MODRM, PH_SIB, PH_DATA} phase_t;

	localparam logic [4:0] CL_MOV = 5'd0, CL_ADD = 5'd1, CL_SUB = 5'd2, CL_AND = 5'd3,
		CL_OR = 5'd4, CL_XOR = 5'd5, CL_CMP = 5'd6, CL_SHL = 5'd7, CL_SHR = 5'd8,
		CL_SAR = 5'd9, CL_BADSH = 5'd10, CL_IMUL = 5'd11, CL_IMULI = 5'd12, CL_JCC = 5'd13,
		CL_JMP = 5'd14, CL_CALL = 5'd15, CL_RET = 5'd16, CL_E_OP = 5'd17, CL_E_OP0F = 5'd18,
		CL_E_SIB = 5'd19, CL_E_MEM = 5'd20, CL_E_TRUNC = 5'd21, CL_E_LONG = 5'd22;

	// byte stage outcome: still decoding, instruction finished, or an error class
	localparam logic [4:0] RS_NONE = 5'd0, RS_DONE = 5'd1;

	localparam logic [1:0] K_REG = 2'd0, K_IMM = 2'd1, K_MEM = 2'd2, K_RIP = 2'd3;

	// decoder state carried between bytes
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  rex;
		logic [8:0]  op;
		logic [7:0]  modrm;
		logic [7:0]  sib;
		logic [63:0] acc;
		logic [3:0]  left;
		logic [3:0]  len;
	} dstate_t;

	// finished instruction handed from the byte stage to the record stage
	typedef struct packed {
		logic [4:0]  err;
		logic [3:0]  rex;
		logic [8:0]  op;
		logic [7:0]  modrm;
		logic [7:0]  sib;
		logic [63:0] acc;
		logic [3:0]  len;
	} done_t;

	function automatic logic is_alu(input logic [8:0] op);
		case (op)
			9'h001, 9'h003, 9'h009, 9'h00B, 9'h021, 9'h023, 9'h029, 9'h02B, 9'h031,
			9'h033, 9'h039, 9'h03B, 9'h089, 9'h08B, 9'h1AF: is_alu = 1'b1;
			default: is_alu = 1'b0;
		endcase
	endfunction

	function automatic logic [3:0] disp_len(input logic [7:0] m, input logic [7:0] s);
		if (m[7:6] == 2'd1) disp_len = 4'd1;
		else if (m[7:6] == 2'd2) disp_len = 4'd4;
		else if (m[7:6] == 2'd0 && m[2:0] == 3'd5) disp_len = 4'd4;
		else if (m[7:6] == 2'd0 && m[2:0] == 3'd4 && s[2:0] == 3'd5) disp_len = 4'd4;
		else disp_len = 4'd0;
	endfunction

	function automatic logic [3:0] data_len(input logic [8:0] op, input logic [7:0] m,
		input logic [7:0] s, input logic [3:0] rex);
		if (is_alu(op)) data_len = disp_len(m, s);
		else if (op == 9'h0C1 || op == 9'h06B || op == 9'h0EB ||
			(op >= 9'h070 && op <= 9'h07F)) data_len = 4'd1;
		else if (op == 9'h069 || op == 9'h0E8 || op == 9'h0E9 ||
			(op >= 9'h180 && op <= 9'h18F)) data_len = 4'd4;
		else if (op >= 9'h0B8 && op <= 9'h0BF) data_len = rex[3] ? 4'd8 : 4'd4;
		else data_len = 4'd0;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/x86_64_subset_insn_decoder.sv
// a record is registered into the output slot, or the skid slot under back-pressure, when its last byte is taken
// throughput: one code byte per cycle while in_stall is low; output register with skid slot
// arst_n clears decode state, offsets, base_address and the output valids
// depends on xid_pkg, xid_byte, xid_rec
`default_nettype none
module x86_64_subset_insn_decoder #(
	parameter int OFFSET_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  code_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       insn_class,
	output logic [1:0]       dst_kind,
	output logic [3:0]       dst_reg,
	output logic [1:0]       src_kind,
	output logic [3:0]       src_reg,
	output logic [3:0]       operand_width,
	output logic signed [31:0] displacement,
	output logic [63:0]      immediate,
	output logic [63:0]      branch_target,
	output logic [3:0]       cond_code,
	output logic [3:0]       insn_length,
	output logic [23:0]      insn_offset
);
	import xid_pkg::*;

	typedef struct packed {
		logic [4:0] c; logic [1:0] dk; logic [3:0] dr; logic [1:0] sk; logic [3:0] sr;
		logic [3:0] w; logic [31:0] dp; logic [63:0] im; logic [63:0] bt;
		logic [3:0] cc; logic [3:0] ln; logic [23:0] of;
	} rec_t;

	logic [63:0] base_q;
	logic take, dv;
	done_t d;
	logic [OFFSET_BITS-1:0] so, eo;
	rec_t nr, out_q, skid_q;
	logic ov_q, sv_q;
	logic [31:0] so32;

	assign in_stall = sv_q;
	assign take = in_valid && !in_stall;

	xid_byte #(.OFFSET_BITS(OFFSET_BITS)) u_byte (
		.clk(clk), .arst_n(arst_n), .take(take), .b(code_byte), .last(last_byte),
		.done(d), .done_v(dv), .start_off(so), .end_off(eo)
	);

	xid_rec #(.OFFSET_BITS(OFFSET_BITS)) u_rec (
		.d(d), .base(base_q), .end_off(eo), .cls(nr.c), .dk(nr.dk), .dr(nr.dr),
		.sk(nr.sk), .sr(nr.sr), .disp(nr.dp), .imm(nr.im), .tgt(nr.bt), .cc(nr.cc)
	);

	assign so32 = 32'(so);
	assign nr.w = d.rex[3] ? 4'd8 : 4'd4;
	assign nr.ln = d.len;
	assign nr.of = so32[23:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			if (cfg_we) base_q <= cfg_wdata;
			if (!ov_q || !out_stall) begin
				// output slot frees: skid first, then new record
				if (sv_q) begin out_q <= skid_q; ov_q <= 1'b1; sv_q <= 1'b0; end
				else begin ov_q <= take && dv; if (take && dv) out_q <= nr; end
			end else if (take && dv) begin
				skid_q <= nr; sv_q <= 1'b1;
			end
		end
	end

	assign out_valid = ov_q;
	assign insn_class = out_q.c;
	assign dst_kind = out_q.dk;
	assign dst_reg = out_q.dr;
	assign src_kind = out_q.sk;
	assign src_reg = out_q.sr;
	assign operand_width = out_q.w;
	assign displacement = out_q.dp;
	assign immediate = out_q.im;
	assign branch_target = out_q.bt;
	assign cond_code = out_q.cc;
	assign insn_length = out_q.ln;
	assign insn_offset = out_q.of;
endmodule
`default_nettype wire

FILE: hw/rtl/xid_byte.sv
// byte stage: prefix/opcode/modrm/sib/data tracking, one byte a cycle while take is high
// depends on xid_pkg
`default_nettype none
module xid_byte #(
	parameter int OFFSET_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   take,
	input  wire logic [7:0]             b,
	input  wire logic                   last,
	output xid_pkg::done_t              done,
	output logic                        done_v,
	output logic [OFFSET_BITS-1:0]      start_off,
	output logic [OFFSET_BITS-1:0]      end_off
);
	import xid_pkg::*;

	dstate_t st_q, nx;
	logic err_q;
	logic [OFFSET_BITS-1:0] off_q, start_q, off_inc, st_now;
	logic [4:0] r;
	dstate_t cur;
	logic [3:0] n;

	assign off_inc = off_q + 1'b1;
	assign st_now = (st_q.len == 4'd0) ? off_q : start_q;

	always_comb begin
		cur = st_q;
		r = RS_NONE;
		n = 4'd0;
		if (st_q.len >= 4'd15) r = CL_E_LONG;
		else begin
			cur.len = st_q.len + 4'd1;
			unique case (st_q.phase)
				PH_ESC: begin
					cur.op = {1'b1, b};
					if (b == 8'hAF) cur.phase = PH_MODRM;
					else if (b >= 8'h80 && b <= 8'h8F) begin
						n = data_len(cur.op, cur.modrm, cur.sib, cur.rex);
						if (n == 4'd0) r = RS_DONE;
						else begin cur.phase = PH_DATA; cur.left = n; end
					end else r = CL_E_OP0F;
				end
				PH_MODRM: begin
					cur.modrm = b;
					n = data_len(cur.op, b, cur.sib, cur.rex);
					if ((st_q.op == 9'h0C1 || st_q.op == 9'h069 || st_q.op == 9'h06B) &&
						b[7:6] != 2'd3) r = CL_E_MEM;
					else if (!(st_q.op == 9'h0C1 || st_q.op == 9'h069 || st_q.op == 9'h06B) &&
						b[7:6] != 2'd3 && b[2:0] == 3'd4) cur.phase = PH_SIB;
					else if (n == 4'd0) r = RS_DONE;
					else begin cur.phase = PH_DATA; cur.left = n; end
				end
				PH_SIB: begin
					cur.sib = b;
					n = data_len(cur.op, cur.modrm, b, cur.rex);
					if (b[5:3] != 3'd4 || st_q.rex[1]) r = CL_E_SIB;
					else if (n == 4'd0) r = RS_DONE;
					else begin cur.phase = PH_DATA; cur.left = n; end
				end
				PH_DATA: begin
					n = data_len(st_q.op, st_q.modrm, st_q.sib, st_q.rex);
					cur.acc = st_q.acc | ({56'd0, b} << {(n - st_q.left) & 4'd7, 3'd0});
					cur.left = st_q.left - 4'd1;
					if (cur.left == 4'd0) r = RS_DONE;
				end
				default: begin
					if (b[7:4] == 4'h4) cur.rex = b[3:0];
					else if (b == 8'h66 || b == 8'h67) cur.rex = 4'd0;
					else begin
						cur.op = {1'b0, b};
						n = data_len(cur.op, cur.modrm, cur.sib, cur.rex);
						if (is_alu(cur.op) || b == 8'hC1 || b == 8'h69 || b == 8'h6B)
							cur.phase = PH_MODRM;
						else if (b == 8'h0F) cur.phase = PH_ESC;
						else if (b == 8'hC3) r = RS_DONE;
						else if (b == 8'hE8 || b == 8'hE9 || b == 8'hEB || b[7:4] == 4'h7 ||
							(b >= 8'hB8 && b <= 8'hBF)) begin
							if (n == 4'd0) r = RS_DONE;
							else begin cur.phase = PH_DATA; cur.left = n; end
						end else r = CL_E_OP;
					end
				end
			endcase
		end
		if (r == RS_NONE && last) r = CL_E_TRUNC;
		nx = (r != RS_NONE || last) ? '0 : cur;
		done = '{err: (r == RS_DONE) ? RS_NONE : r, rex: cur.rex, op: cur.op,
			modrm: cur.modrm, sib: cur.sib, acc: cur.acc, len: cur.len};
		done_v = take && !err_q && r != RS_NONE;
	end

	assign start_off = st_now;
	assign end_off = off_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			err_q <= 1'b0;
			off_q <= '0;
			start_q <= '0;
		end else if (take) begin
			off_q <= last ? '0 : off_inc;
			if (err_q) begin
				if (last) begin err_q <= 1'b0; st_q <= '0; end
			end else begin
				start_q <= st_now;
				st_q <= nx;
				if (r != RS_NONE && r != RS_DONE && !last) err_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/xid_rec.sv
// record stage: forms class, operand fields, displacement, immediate, condition code and branch target
// depends on xid_pkg
`default_nettype none
module xid_rec #(
	parameter int OFFSET_BITS = 24
) (
	input  xid_pkg::done_t          d,
	input  wire logic [63:0]        base,
	input  wire logic [OFFSET_BITS-1:0] end_off,
	output logic [4:0]              cls,
	output logic [1:0]              dk,
	output logic [3:0]              dr,
	output logic [1:0]              sk,
	output logic [3:0]              sr,
	output logic [31:0]             disp,
	output logic [63:0]             imm,
	output logic [63:0]             tgt,
	output logic [3:0]              cc
);
	import xid_pkg::*;

	logic [1:0] mod;
	logic [3:0] regf, rmf, mreg;
	logic [1:0] kind;
	logic [63:0] rel;
	logic br;

	always_comb begin
		mod = d.modrm[7:6];
		regf = {d.rex[2], d.modrm[5:3]};
		rmf = {d.rex[0], d.modrm[2:0]};
		cls = CL_MOV; dk = K_REG; dr = 4'd0; sk = K_REG; sr = 4'd0;
		disp = 32'd0; imm = 64'd0; cc = 4'd0; rel = 64'd0; br = 1'b0;
		kind = K_REG; mreg = rmf;
		if (mod != 2'd3) begin
			kind = K_MEM;
			if (rmf[2:0] == 3'd4) begin
				mreg = {d.rex[0], d.sib[2:0]};
				if (d.sib[2:0] == 3'd5 && mod == 2'd0) begin kind = K_RIP; mreg = 4'd0; end
			end else if (rmf[2:0] == 3'd5 && mod == 2'd0) begin kind = K_RIP; mreg = 4'd0; end
		end
		if (d.err != RS_NONE) cls = d.err;
		else if (is_alu(d.op)) begin
			case (d.op)
				9'h089, 9'h08B: cls = CL_MOV;
				9'h001, 9'h003: cls = CL_ADD;
				9'h029, 9'h02B: cls = CL_SUB;
				9'h021, 9'h023: cls = CL_AND;
				9'h009, 9'h00B: cls = CL_OR;
				9'h031, 9'h033: cls = CL_XOR;
				9'h039, 9'h03B: cls = CL_CMP;
				default: cls = CL_IMUL;
			endcase
			if (mod == 2'd1) disp = {{24{d.acc[7]}}, d.acc[7:0]};
			else if (mod == 2'd2 || kind == K_RIP) disp = d.acc[31:0];
			if (d.op[1] || d.op == 9'h1AF) begin dr = regf; sk = kind; sr = mreg; end
			else begin dk = kind; dr = mreg; sr = regf; end
		end else if (d.op == 9'h0C1) begin
			case (d.modrm[5:3])
				3'd4: cls = CL_SHL;
				3'd5: cls = CL_SHR;
				3'd7: cls = CL_SAR;
				default: cls = CL_BADSH;
			endcase
			dr = rmf; sk = K_IMM; imm = {56'd0, d.acc[7:0]};
		end else if (d.op == 9'h069 || d.op == 9'h06B) begin
			cls = CL_IMULI; dr = regf; sr = rmf; imm = d.acc;
		end else if (d.op[7:4] == 4'h7 && !d.op[8] || d.op[8:4] == 5'h18) begin
			cls = CL_JCC; cc = d.op[3:0]; br = 1'b1;
			rel = d.op[8] ? {{32{d.acc[31]}}, d.acc[31:0]} : {{56{d.acc[7]}}, d.acc[7:0]};
		end else if (d.op == 9'h0E9 || d.op == 9'h0EB) begin
			cls = CL_JMP; br = 1'b1;
			rel = d.op[1] ? {{56{d.acc[7]}}, d.acc[7:0]} : {{32{d.acc[31]}}, d.acc[31:0]};
		end else if (d.op == 9'h0E8) begin
			cls = CL_CALL; br = 1'b1; rel = {{32{d.acc[31]}}, d.acc[31:0]};
		end else if (d.op == 9'h0C3) cls = CL_RET;
		else begin
			dr = {d.rex[0], d.op[2:0]}; sk = K_IMM; imm = d.acc;
		end
		tgt = br ? base + 64'(end_off) + rel : 64'd0;
	end
endmodule
`default_nettype wire

FILE: hw/rtl/xid_checker.sv
// port-level checks for the decoder, bound to the top level
// depends on x86_64_subset_insn_decoder ports only
`default_nettype none
module xid_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [4:0] insn_class,
	input wire logic [3:0] insn_length,
	input wire logic [3:0] operand_width
);
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> insn_length != 4'd0) else $error("zero length");
	a_cls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> insn_class <= 5'd22) else $error("bad class");
	a_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (operand_width == 4'd4 || operand_width == 4'd8)) else $error("bad width");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(insn_class)) else $error("record lost");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall)) else $error("stall without back-pressure");
endmodule

bind x86_64_subset_insn_decoder xid_checker u_chk (.*);
`default_nettype wire

FILE: sim/tb_x86_64_subset_insn_decoder.sv
// testbench for the x86-64 subset instruction decoder: byte stream in, decoded records out
// holds its own decoder predictor and compares each record as a whole; depends on xid_pkg
`timescale 1ns / 1ps
module tb_x86_64_subset_insn_decoder;
	import xid_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} code_t;

	typedef struct packed {
		logic [4:0]  cls;
		logic [1:0]  dk;
		logic [3:0]  dr;
		logic [1:0]  sk;
		logic [3:0]  sr;
		logic [3:0]  w;
		logic [31:0] disp;
		logic [63:0] imm;
		logic [63:0] tgt;
		logic [3:0]  cc;
		logic [3:0]  len;
		logic [23:0] off;
	} rec_t;

	localparam logic [2:0] P_PFX = 3'd0, P_ESC = 3'd1, P_MODRM = 3'd2, P_SIB = 3'd3,
		P_DATA = 3'd4;
	localparam logic [4:0] R_NONE = 5'd0, R_DONE = 5'd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic [7:0] code_byte = '0;
	logic last_byte = 1'b0;
	logic out_stall = 1'b0;
	wire in_stall, out_valid;
	wire [4:0] insn_class;
	wire [1:0] dst_kind, src_kind;
	wire [3:0] dst_reg, src_reg, operand_width, cond_code, insn_length;
	wire signed [31:0] displacement;
	wire [63:0] immediate, branch_target;
	wire [23:0] insn_offset;

	x86_64_subset_insn_decoder DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .code_byte(code_byte),
		.last_byte(last_byte), .out_valid(out_valid), .out_stall(out_stall),
		.insn_class(insn_class), .dst_kind(dst_kind), .dst_reg(dst_reg),
		.src_kind(src_kind), .src_reg(src_reg), .operand_width(operand_width),
		.displacement(displacement), .immediate(immediate), .branch_target(branch_target),
		.cond_code(cond_code), .insn_length(insn_length), .insn_offset(insn_offset)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [63:0] base_q = '0;
	logic [23:0] pos = '0, first_pos = '0;
	logic [2:0]  phase = P_PFX;
	logic [3:0]  rex = '0, left = '0, count = '0;
	logic [8:0]  opc = '0;
	logic [7:0]  modrm = '0, sib = '0;
	logic [63:0] acc = '0;
	logic        dropping = 1'b0;

	code_t pending_bytes[$];
	rec_t  expected_recs[$];
	int    mismatches = 0;
	int    hold_req = 0;
	int    hold_seen = 0;
	int    hold_off = 0;
	bit    stim_done = 0;

	function automatic bit alu_op(logic [8:0] op);
		case (op)
			9'h001, 9'h003, 9'h009, 9'h00B, 9'h021, 9'h023, 9'h029, 9'h02B, 9'h031,
			9'h033, 9'h039, 9'h03B, 9'h089, 9'h08B, 9'h1AF: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [3:0] field_bytes();
		if (alu_op(opc)) begin
			if (modrm[7:6] == 2'd1) return 4'd1;
			if (modrm[7:6] == 2'd2) return 4'd4;
			if (modrm[7:6] == 2'd0 && modrm[2:0] == 3'd5) return 4'd4;
			if (modrm[7:6] == 2'd0 && modrm[2:0] == 3'd4 && sib[2:0] == 3'd5) return 4'd4;
			return 4'd0;
		end
		if (opc == 9'h0C1 || opc == 9'h06B || opc == 9'h0EB ||
			(opc >= 9'h070 && opc <= 9'h07F)) return 4'd1;
		if (opc == 9'h069 || opc == 9'h0E8 || opc == 9'h0E9 ||
			(opc >= 9'h180 && opc <= 9'h18F)) return 4'd4;
		if (opc >= 9'h0B8 && opc <= 9'h0BF) return rex[3] ? 4'd8 : 4'd4;
		return 4'd0;
	endfunction

	task automatic clear_insn();
		phase = P_PFX; rex = 0; opc = 0; modrm = 0; sib = 0; acc = 0; left = 0; count = 0;
	endtask

	function automatic logic [4:0] enter_data();
		logic [3:0] n;
		n = field_bytes();
		if (n == 0) return R_DONE;
		phase = P_DATA; left = n;
		return R_NONE;
	endfunction

	function automatic logic [4:0] consume(logic [7:0] b);
		logic [3:0] n;
		case (phase)
			P_ESC: begin
				opc = {1'b1, b};
				if (b == 8'hAF) begin
					phase = P_MODRM; return R_NONE;
				end
				if (b >= 8'h80 && b <= 8'h8F) return enter_data();
				return CL_E_OP0F;
			end
			P_MODRM: begin
				modrm = b;
				if (opc == 9'h0C1 || opc == 9'h069 || opc == 9'h06B) begin
					if (b[7:6] != 2'd3) return CL_E_MEM;
					return enter_data();
				end
				if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
					phase = P_SIB; return R_NONE;
				end
				return enter_data();
			end
			P_SIB: begin
				sib = b;
				if (b[5:3] != 3'd4 || rex[1]) return CL_E_SIB;
				return enter_data();
			end
			P_DATA: begin
				n = field_bytes();
				acc |= 64'(b) << (8 * ((n - left) & 7));
				left = left - 1;
				return left == 0 ? R_DONE : R_NONE;
			end
			default: begin
				if (b >= 8'h40 && b <= 8'h4F) begin
					rex = b[3:0]; return R_NONE;
				end
				if (b == 8'h66 || b == 8'h67) begin
					rex = 0; return R_NONE;
				end
				opc = {1'b0, b};
				if (alu_op(opc) || b == 8'hC1 || b == 8'h69 || b == 8'h6B) begin
					phase = P_MODRM; return R_NONE;
				end
				if (b == 8'h0F) begin
					phase = P_ESC; return R_NONE;
				end
				if (b == 8'hC3) return R_DONE;
				if (b == 8'hE8 || b == 8'hE9 || b == 8'hEB || (b >= 8'h70 && b <= 8'h7F) ||
					(b >= 8'hB8 && b <= 8'hBF)) return enter_data();
				return CL_E_OP;
			end
		endcase
	endfunction

	task automatic fill_record(inout rec_t r);
		logic [3:0] regf, rmf, breg;
		logic [1:0] kind;
		logic [63:0] rel;
		bit branch;
		regf = {rex[2], modrm[5:3]};
		rmf = {rex[0], modrm[2:0]};
		rel = 0; branch = 0;
		if (alu_op(opc)) begin
			kind = K_REG; breg = rmf;
			if (modrm[7:6] != 2'd3) begin
				kind = K_MEM;
				if (modrm[2:0] == 3'd4) begin
					breg = {rex[0], sib[2:0]};
					if (sib[2:0] == 3'd5 && modrm[7:6] == 2'd0) begin
						kind = K_RIP; breg = 0;
					end
				end else if (modrm[2:0] == 3'd5 && modrm[7:6] == 2'd0) begin
					kind = K_RIP; breg = 0;
				end
				if (modrm[7:6] == 2'd1) r.disp = {{24{acc[7]}}, acc[7:0]};
				else if (modrm[7:6] == 2'd2 || kind == K_RIP) r.disp = acc[31:0];
			end
			case (opc)
				9'h089, 9'h08B: r.cls = CL_MOV;
				9'h001, 9'h003: r.cls = CL_ADD;
				9'h029, 9'h02B: r.cls = CL_SUB;
				9'h021, 9'h023: r.cls = CL_AND;
				9'h009, 9'h00B: r.cls = CL_OR;
				9'h031, 9'h033: r.cls = CL_XOR;
				9'h039, 9'h03B: r.cls = CL_CMP;
				default: r.cls = CL_IMUL;
			endcase
			if (opc[1] || opc == 9'h1AF) begin
				r.dk = K_REG; r.dr = regf; r.sk = kind; r.sr = breg;
			end else begin
				r.dk = kind; r.dr = breg; r.sk = K_REG; r.sr = regf;
			end
		end else if (opc == 9'h0C1) begin
			case (modrm[5:3])
				3'd4: r.cls = CL_SHL;
				3'd5: r.cls = CL_SHR;
				3'd7: r.cls = CL_SAR;
				default: r.cls = CL_BADSH;
			endcase
			r.dr = rmf; r.sk = K_IMM; r.imm = {56'd0, acc[7:0]};
		end else if (opc == 9'h069 || opc == 9'h06B) begin
			r.cls = CL_IMULI; r.dr = regf; r.sr = rmf; r.imm = acc;
		end else if ((opc >= 9'h070 && opc <= 9'h07F) || (opc >= 9'h180 && opc <= 9'h18F)) begin
			r.cls = CL_JCC; r.cc = opc[3:0]; branch = 1;
			rel = opc[8] ? {{32{acc[31]}}, acc[31:0]} : {{56{acc[7]}}, acc[7:0]};
		end else if (opc == 9'h0E9 || opc == 9'h0EB) begin
			r.cls = CL_JMP; branch = 1;
			rel = opc == 9'h0EB ? {{56{acc[7]}}, acc[7:0]} : {{32{acc[31]}}, acc[31:0]};
		end else if (opc == 9'h0E8) begin
			r.cls = CL_CALL; branch = 1; rel = {{32{acc[31]}}, acc[31:0]};
		end else if (opc == 9'h0C3) begin
			r.cls = CL_RET;
		end else begin
			r.cls = CL_MOV; r.dr = {rex[0], opc[2:0]}; r.sk = K_IMM; r.imm = acc;
		end
		if (branch) r.tgt = base_q + 64'(pos) + rel;
	endtask

	// advances the decoder by one code byte; queues a record when one is due
	task automatic decode_byte(code_t c);
		logic [4:0] res;
		rec_t r;
		if (dropping) begin
			if (c.last) begin
				pos = 0; dropping = 0; clear_insn();
			end else pos = pos + 1;
			return;
		end
		if (count == 0) first_pos = pos;
		if (count >= 4'd15) res = CL_E_LONG;
		else begin
			count = count + 1; res = R_NONE;
		end
		pos = pos + 1;
		if (res == R_NONE) res = consume(c.b);
		if (res == R_NONE && c.last) res = CL_E_TRUNC;
		if (res != R_NONE) begin
			r = '0;
			r.w = rex[3] ? 4'd8 : 4'd4;
			r.len = count;
			r.off = first_pos;
			if (res == R_DONE) fill_record(r);
			else begin
				r.cls = res;
				if (!c.last) dropping = 1;
			end
			expected_recs.insert(expected_recs.size(), r);
			clear_insn();
		end
		if (c.last) begin
			pos = 0; clear_insn();
		end
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (in_valid) decode_byte('{code_byte, last_byte});
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					code_t c;
					c = pending_bytes.pop_front();
					in_valid <= 1'b1;
					code_byte <= c.b;
					last_byte <= c.last;
					send_gap <= gap_len();
				end else in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, started on request from the stimulus
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_off <= 400;
		end else if (hold_off > 0) hold_off <= hold_off - 1;
	end

	// monitor and receiver stalls
	int recv_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				rec_t got, want;
				got = '{insn_class, dst_kind, dst_reg, src_kind, src_reg, operand_width,
					displacement, immediate, branch_target, cond_code, insn_length, insn_offset};
				if (expected_recs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected record %p", got);
				end else begin
					want = expected_recs.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) $display("mismatch\n exp %p\n got %p", want, got);
					end
				end
			end
			if (hold_off > 0) begin
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				recv_gap <= gap_len();
			end
		end
	end

	task automatic append_byte(ref logic [7:0] q[$], input logic [7:0] v);
		q.insert(q.size(), v);
	endtask

	task automatic add_bytes(input logic [7:0] bs[$], input bit end_region);
		foreach (bs[i])
			pending_bytes.insert(pending_bytes.size(),
				code_t'{bs[i], end_region && i == bs.size() - 1});
	endtask

	task automatic drain();
		while (pending_bytes.size() > 0 || in_valid || expected_recs.size() > 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_base(logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		base_q = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] rnd_modrm(bit regonly);
		logic [7:0] m;
		m = $urandom;
		if (regonly) m[7:6] = 2'd3;
		return m;
	endfunction

	// one instruction with random content; a random REX prefix can make it decode as an error
	task automatic add_random_insn(ref logic [7:0] bs[$]);
		logic [7:0] alu[15] = '{8'h01, 8'h03, 8'h09, 8'h0B, 8'h21, 8'h23, 8'h29, 8'h2B,
			8'h31, 8'h33, 8'h39, 8'h3B, 8'h89, 8'h8B, 8'h0F};
		logic [7:0] m;
		int k, n;
		if ($urandom_range(0, 2) == 0) append_byte(bs, 8'h40 | 8'($urandom_range(0, 15)));
		if ($urandom_range(0, 9) == 0) append_byte(bs, $urandom_range(0, 1) ? 8'h66 : 8'h67);
		k = $urandom_range(0, 9);
		n = 0;
		case (k)
			0, 1, 2: begin
				append_byte(bs, alu[$urandom_range(0, 14)]);
				if (bs[$] == 8'h0F) append_byte(bs, 8'hAF);
				m = rnd_modrm(0);
				append_byte(bs, m);
				if (m[7:6] != 2'd3 && m[2:0] == 3'd4) begin
					append_byte(bs, {m[0] ? 2'($urandom) : 2'd0, 3'd4, 3'($urandom)});
					if (m[7:6] == 2'd0 && bs[$][2:0] == 3'd5) n = 4;
				end
				if (m[7:6] == 2'd1) n = 1;
				else if (m[7:6] == 2'd2 || (m[7:6] == 2'd0 && m[2:0] == 3'd5)) n = 4;
			end
			3: begin
				append_byte(bs, 8'hC1); append_byte(bs, rnd_modrm(1)); n = 1;
			end
			4: begin
				append_byte(bs, $urandom_range(0, 1) ? 8'h69 : 8'h6B);
				n = bs[$] == 8'h69 ? 4 : 1;
				append_byte(bs, rnd_modrm(1));
			end
			5: begin
				append_byte(bs, 8'h70 | 8'($urandom_range(0, 15))); n = 1;
			end
			6: begin
				append_byte(bs, 8'h0F); append_byte(bs, 8'h80 | 8'($urandom_range(0, 15))); n = 4;
			end
			7: begin
				append_byte(bs, 8'hE8 | 8'($urandom_range(0, 3)));
				if (bs[$] == 8'hEA) bs[$] = 8'hC3;
				n = bs[$] == 8'hEB ? 1 : bs[$] == 8'hC3 ? 0 : 4;
			end
			default: begin
				append_byte(bs, 8'hB8 | 8'($urandom_range(0, 7)));
				n = (bs.size() > 1 && bs[0][7:4] == 4'h4 && bs[0][3]) ? 8 : 4;
			end
		endcase
		repeat (n) append_byte(bs, 8'($urandom));
	endtask

	initial begin
		logic [7:0] bs[$];
		int total;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: one region per group of cases
		set_base(64'hFFFF_FFFF_FFFF_FFF0);
		bs = '{8'h48, 8'h89, 8'hC8}; add_bytes(bs, 1);
		bs = '{8'h4D, 8'h03, 8'h84, 8'h24, 8'h78, 8'h56, 8'h34, 8'h12}; add_bytes(bs, 1);
		bs = '{8'h8B, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h2B, 8'h45, 8'h80}; add_bytes(bs, 1);
		bs = '{8'h33, 8'h04, 8'h25, 8'h01, 8'h00, 8'h00, 8'h80}; add_bytes(bs, 1);
		bs = '{8'h48, 8'hC1, 8'hE0, 8'hFF, 8'hC1, 8'hE8, 8'h00, 8'hC1, 8'hF8, 8'h01,
			8'hC1, 8'hC0, 8'h02}; add_bytes(bs, 1);
		bs = '{8'h0F, 8'hAF, 8'hC1, 8'h69, 8'hC1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h6B, 8'hC1, 8'h80}; add_bytes(bs, 1);
		bs = '{8'h7F, 8'h80, 8'h0F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h80, 8'hEB, 8'h7F,
			8'hE9, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hE8, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC3};
		add_bytes(bs, 1);
		bs = '{8'h48, 8'h66, 8'hBF, 8'h11, 8'h22, 8'h33, 8'h44,
			8'h4F, 8'hB8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		add_bytes(bs, 1);
		bs = '{8'hFF, 8'h90, 8'h90}; add_bytes(bs, 1);
		bs = '{8'h0F, 8'h05, 8'h11}; add_bytes(bs, 1);
		bs = '{8'h89, 8'h04, 8'h88, 8'h01}; add_bytes(bs, 1);
		bs = '{8'h42, 8'h89, 8'h04, 8'h24}; add_bytes(bs, 1);
		bs = '{8'hC1, 8'h00, 8'h05}; add_bytes(bs, 1);
		bs = '{8'h89, 8'h45}; add_bytes(bs, 1);
		bs = '{8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66,
			8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'hC3}; add_bytes(bs, 1);
		drain();

		// long receiver hold-off while bytes keep coming
		set_base(64'h0);
		bs = {};
		repeat (40) add_random_insn(bs);
		add_bytes(bs, 1);
		hold_req = hold_req + 1;
		drain();

		// random regions over several base addresses
		total = 0;
		for (int phase_no = 0; phase_no < 4; phase_no++) begin
			case (phase_no)
				0: set_base(64'hFFFF_FFFF_FFFF_FFFF);
				1: set_base({$urandom, $urandom});
				2: set_base(64'h0000_0000_0040_0000);
				default: set_base({$urandom, $urandom});
			endcase
			while (total < 100 * (phase_no + 1)) begin
				bs = {};
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 19) == 0) append_byte(bs, 8'($urandom));
					else add_random_insn(bs);
				end
				if ($urandom_range(0, 9) == 0) bs.delete(bs.size() - 1);
				if (bs.size() == 0) append_byte(bs, 8'hC3);
				total += bs.size();
				add_bytes(bs, 1);
			end
			drain();
		end
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (mismatches == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end
endmodule

FILE: x86_64_subset_insn_decoder.f
hw/rtl/xid_pkg.sv
hw/rtl/xid_byte.sv
hw/rtl/xid_rec.sv
hw/rtl/x86_64_subset_insn_decoder.sv
hw/rtl/xid_checker.sv
sim/tb_x86_64_subset_insn_decoder.sv
